@@ src/mifp_pkg.sv @@
// Shared types and constants for the marked input field parser.
package mifp_pkg;

    // Parse phase of the byte string
    typedef enum logic [1:0] {
        PH_INFO    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_SPECIAL = 2'd2
    } t_phase;

    // Sort and emit sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_PREP  = 3'd1,
        S_LOAD  = 3'd2,
        S_FIRST = 3'd3,
        S_CMP   = 3'd4,
        S_TAIL  = 3'd5,
        S_EMRD  = 3'd6,
        S_EMIT  = 3'd7
    } t_seq_state;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CHECK_MARK     = 2'd0,
        CFG_LENGTH_MARK    = 2'd1,
        CFG_SPECIAL_MARK   = 2'd2,
        CFG_DEFAULT_LENGTH = 2'd3
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic [7:0]  check_mark;
        logic [7:0]  length_mark;
        logic [7:0]  special_mark;
        logic [15:0] default_length;
    } t_cfg;

    // Sequencer to top level: result load control
    typedef struct packed {
        logic       busy;
        logic       load;
        logic       last;
        logic       byte_vld;
        logic [7:0] sbyte;
        logic       clear;
    } t_seq_ctl;

    localparam int        CFG_IDX_W      = 2;
    localparam int        CFG_DATA_W     = 16;
    localparam logic [7:0]  RST_CHECK    = 8'd33;
    localparam logic [7:0]  RST_LENGTH   = 8'd35;
    localparam logic [7:0]  RST_SPECIAL  = 8'd36;
    localparam logic [15:0] RST_DEF_LEN  = 16'd16;
    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;
    localparam logic [19:0] LEN_SAT      = 20'h0FFFF;
    localparam int        LEN_W          = 16;

endpackage

@@ src/marked_input_field_parser.sv @@
// Top level of the marked input field parser.
//
//  Channel  | Direction | Handshake               | Content
//  ---------+-----------+-------------------------+----------------------------------------
//  s        | in        | i_s_tvalid / o_s_tready | tdata: in_byte; tlast: in_last
//  m        | out       | o_m_tvalid / i_m_tready | tdata: summary and sorted byte;
//           |           |                         | tuser: special_valid; tlast: run_last
//  cfg      | in        | i_cfg_valid/o_cfg_ready | index and data of one register
//
//  A byte without tlast is taken whenever o_s_tready is high. A byte with tlast holds o_s_tready
//  low while the store of special bytes is bubble sorted and read out, with the single compare
//  and the single store read port; a stalled output also holds up the readout.
//  Reset is synchronous and active low; the store has no clearing pass.
//  The output register lets the next string start while the final result waits.
module marked_input_field_parser #(
    parameter int MAX_SPECIAL = 32,
    parameter int MAX_STRING  = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    input  logic [7:0]                                  i_s_tdata,  // [7:0] in_byte
    input  logic                                        i_s_tlast,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // lowest bit up: has_check, info_count, length_value, special_count, special_byte,
    // special_overflow, zero fill
    output logic [((($clog2(MAX_STRING+1)+$clog2(MAX_SPECIAL+1)+26)+7)/8)*8-1:0] o_m_tdata,
    output logic                                        o_m_tuser,  // [0] special_valid
    output logic                                        o_m_tlast,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [mifp_pkg::CFG_IDX_W-1:0]              i_cfg_index,
    input  logic [mifp_pkg::CFG_DATA_W-1:0]             i_cfg_data
);

    localparam int IW = $clog2(MAX_STRING + 1);
    localparam int CW = $clog2(MAX_SPECIAL + 1);
    localparam int AW = $clog2(MAX_SPECIAL);
    localparam int FW = IW + CW + 26;
    localparam int DW = ((FW + 7) / 8) * 8;

    mifp_pkg::t_cfg     r_cfg;
    mifp_pkg::t_seq_ctl w_ctl;

    logic               w_take;
    logic               w_start;
    logic               w_out_free;
    logic               w_has_check;
    logic [IW-1:0]      w_info;
    logic [15:0]        w_len;
    logic [CW-1:0]      w_cnt;
    logic               w_ovf;
    logic               w_p_we;
    logic [AW-1:0]      w_p_waddr;
    logic [7:0]         w_p_wdata;
    logic               w_s_we;
    logic [AW-1:0]      w_s_waddr;
    logic [7:0]         w_s_wdata;
    logic [AW-1:0]      w_raddr;
    logic [7:0]         w_rdata;

    logic               r_out_valid;
    logic [FW-1:0]      r_out_data;
    logic               r_out_user;
    logic               r_out_last;

    assign o_s_tready  = !w_ctl.busy;
    assign o_cfg_ready = 1'b1;
    assign w_take      = i_s_tvalid && o_s_tready;
    assign w_start     = w_take && i_s_tlast;
    assign w_out_free  = !r_out_valid || i_m_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_mark     <= mifp_pkg::RST_CHECK;
            r_cfg.length_mark    <= mifp_pkg::RST_LENGTH;
            r_cfg.special_mark   <= mifp_pkg::RST_SPECIAL;
            r_cfg.default_length <= mifp_pkg::RST_DEF_LEN;
        end else if (i_cfg_valid) begin
            case (mifp_pkg::t_cfg_idx'(i_cfg_index))
                mifp_pkg::CFG_CHECK_MARK:     r_cfg.check_mark     <= i_cfg_data[7:0];
                mifp_pkg::CFG_LENGTH_MARK:    r_cfg.length_mark    <= i_cfg_data[7:0];
                mifp_pkg::CFG_SPECIAL_MARK:   r_cfg.special_mark   <= i_cfg_data[7:0];
                mifp_pkg::CFG_DEFAULT_LENGTH: r_cfg.default_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mifp_parse #(
        .MAX_SPECIAL (MAX_SPECIAL),
        .MAX_STRING  (MAX_STRING)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_byte          (i_s_tdata),
        .i_clear         (w_ctl.clear),
        .i_cfg           (r_cfg),
        .o_has_check     (w_has_check),
        .o_info_count    (w_info),
        .o_length_value  (w_len),
        .o_special_count (w_cnt),
        .o_overflow      (w_ovf),
        .o_we            (w_p_we),
        .o_waddr         (w_p_waddr),
        .o_wdata         (w_p_wdata)
    );

    mifp_sort #(
        .MAX_SPECIAL (MAX_SPECIAL)
    ) u_sort (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_count    (w_cnt),
        .i_out_free (w_out_free),
        .i_rdata    (w_rdata),
        .o_raddr    (w_raddr),
        .o_we       (w_s_we),
        .o_waddr    (w_s_waddr),
        .o_wdata    (w_s_wdata),
        .o_ctl      (w_ctl)
    );

    // Store: the parser writes while idle, the sequencer while sorting
    mifp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SPECIAL)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_p_we || w_s_we),
        .i_waddr (w_ctl.busy ? w_s_waddr : w_p_waddr),
        .i_wdata (w_ctl.busy ? w_s_wdata : w_p_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output register: load a result, drop it once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_out_data <= {w_ovf, w_ctl.sbyte, w_cnt, w_len, w_info, w_has_check};
            r_out_user <= w_ctl.byte_vld;
            r_out_last <= w_ctl.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DW'(r_out_data);
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

@@ src/mifp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mifp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mifp_parse.sv @@
// Byte parser: check mark, information count, length field and special byte store writes.
module mifp_parse #(
    parameter int MAX_SPECIAL = 32,
    parameter int MAX_STRING  = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_take,
    input  logic [7:0]                           i_byte,
    input  logic                                 i_clear,
    input  mifp_pkg::t_cfg                       i_cfg,
    output logic                                 o_has_check,
    output logic [$clog2(MAX_STRING+1)-1:0]      o_info_count,
    output logic [mifp_pkg::LEN_W-1:0]           o_length_value,
    output logic [$clog2(MAX_SPECIAL+1)-1:0]     o_special_count,
    output logic                                 o_overflow,
    output logic                                 o_we,
    output logic [$clog2(MAX_SPECIAL)-1:0]       o_waddr,
    output logic [7:0]                           o_wdata
);

    localparam int IW = $clog2(MAX_STRING + 1);
    localparam int CW = $clog2(MAX_SPECIAL + 1);
    localparam int AW = $clog2(MAX_SPECIAL);
    localparam logic [IW-1:0] INFO_MAX = IW'(MAX_STRING);
    localparam logic [CW-1:0] SPEC_MAX = CW'(MAX_SPECIAL);

    mifp_pkg::t_phase          r_phase, n_phase;
    logic                      r_first, n_first;
    logic                      r_check, n_check;
    logic [IW-1:0]             r_info, n_info;
    logic                      r_len_seen, n_len_seen;
    logic [mifp_pkg::LEN_W-1:0] r_acc, n_acc;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_ovf, n_ovf;

    logic                      w_is_check;
    logic                      w_is_len;
    logic                      w_is_spec;
    logic                      w_is_digit;
    logic [19:0]               w_acc_next;

    assign w_is_check = (i_byte == i_cfg.check_mark);
    assign w_is_len   = (i_byte == i_cfg.length_mark);
    assign w_is_spec  = (i_byte == i_cfg.special_mark);
    assign w_is_digit = (i_byte >= mifp_pkg::CH_ZERO) && (i_byte <= mifp_pkg::CH_NINE);

    // Accumulate one decimal digit: acc * 10 as two shifted copies, plus the digit
    assign w_acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                      + {16'd0, i_byte[3:0]};

    // Next parse state for one accepted byte
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_check    = r_check;
        n_info     = r_info;
        n_len_seen = r_len_seen;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        o_we       = 1'b0;
        if (i_take) begin
            n_first = 1'b0;
            if (r_first) begin
                n_check = w_is_check;
            end
            case (r_phase)
                mifp_pkg::PH_INFO: begin
                    if (w_is_spec) begin
                        n_phase = mifp_pkg::PH_SPECIAL;
                    end else if (w_is_len) begin
                        n_phase    = mifp_pkg::PH_LENGTH;
                        n_len_seen = 1'b1;
                        n_acc      = '0;
                    end else if (!(r_first && w_is_check) && (r_info < INFO_MAX)) begin
                        n_info = r_info + IW'(1);
                    end
                end
                mifp_pkg::PH_LENGTH: begin
                    if (w_is_spec) begin
                        n_phase = mifp_pkg::PH_SPECIAL;
                    end else if (w_is_digit) begin
                        n_acc = (w_acc_next > mifp_pkg::LEN_SAT) ? '1 : w_acc_next[15:0];
                    end
                end
                default: begin
                    if (r_cnt < SPEC_MAX) begin
                        o_we  = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            endcase
        end
    end

    // Hold parse state; return to the start of a string on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase    <= mifp_pkg::PH_INFO;
            r_first    <= 1'b1;
            r_check    <= 1'b0;
            r_info     <= '0;
            r_len_seen <= 1'b0;
            r_acc      <= '0;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_check    <= n_check;
            r_info     <= n_info;
            r_len_seen <= n_len_seen;
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
        end
    end

    assign o_waddr         = r_cnt[AW-1:0];
    assign o_wdata         = i_byte;
    assign o_has_check     = r_check;
    assign o_info_count    = r_info;
    assign o_length_value  = r_len_seen ? r_acc : i_cfg.default_length;
    assign o_special_count = r_cnt;
    assign o_overflow      = r_ovf;

endmodule

@@ src/mifp_sort.sv @@
// Sort and emit sequencer: bubble sort over the store with one shared compare, then readout.
module mifp_sort #(
    parameter int MAX_SPECIAL = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_SPECIAL+1)-1:0]  i_count,
    input  logic                              i_out_free,
    input  logic [7:0]                        i_rdata,
    output logic [$clog2(MAX_SPECIAL)-1:0]    o_raddr,
    output logic                              o_we,
    output logic [$clog2(MAX_SPECIAL)-1:0]    o_waddr,
    output logic [7:0]                        o_wdata,
    output mifp_pkg::t_seq_ctl                o_ctl
);

    localparam int AW = $clog2(MAX_SPECIAL);
    localparam int CW = $clog2(MAX_SPECIAL + 1);

    mifp_pkg::t_seq_state r_state, n_state;
    logic [AW-1:0]        r_k, n_k;
    logic [AW-1:0]        r_hi, n_hi;
    logic [7:0]           r_c, n_c;

    logic [AW-1:0]        w_top;
    logic                 w_swap;
    logic                 w_none;
    logic                 w_emit_last;

    // Highest occupied entry, and the shared compare of carry against the read entry
    assign w_top       = AW'(i_count - CW'(1));
    assign w_swap      = (r_c > i_rdata);
    assign w_none      = (i_count == '0);
    assign w_emit_last = w_none || (r_k == w_top);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mifp_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = mifp_pkg::S_PREP;
                end
            end
            mifp_pkg::S_PREP: begin
                n_state = (i_count > CW'(1)) ? mifp_pkg::S_LOAD : mifp_pkg::S_EMRD;
            end
            mifp_pkg::S_LOAD:  n_state = mifp_pkg::S_FIRST;
            mifp_pkg::S_FIRST: n_state = mifp_pkg::S_CMP;
            mifp_pkg::S_CMP: begin
                if (r_k == r_hi) begin
                    n_state = mifp_pkg::S_TAIL;
                end
            end
            mifp_pkg::S_TAIL: begin
                n_state = (r_hi == AW'(1)) ? mifp_pkg::S_EMRD : mifp_pkg::S_LOAD;
            end
            mifp_pkg::S_EMRD: n_state = mifp_pkg::S_EMIT;
            mifp_pkg::S_EMIT: begin
                if (i_out_free && w_emit_last) begin
                    n_state = mifp_pkg::S_IDLE;
                end
            end
            default: n_state = mifp_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        n_k          = r_k;
        n_hi         = r_hi;
        n_c          = r_c;
        o_raddr      = '0;
        o_we         = 1'b0;
        o_waddr      = '0;
        o_wdata      = r_c;
        o_ctl.busy     = (r_state != mifp_pkg::S_IDLE);
        o_ctl.load     = 1'b0;
        o_ctl.last     = w_emit_last;
        o_ctl.byte_vld = !w_none;
        o_ctl.sbyte    = w_none ? 8'd0 : i_rdata;
        o_ctl.clear    = 1'b0;
        case (r_state)
            mifp_pkg::S_PREP: begin
                n_hi = w_top;
                n_k  = '0;
            end
            mifp_pkg::S_LOAD: begin
                o_raddr = '0;
            end
            // Take entry zero as the carry, fetch entry one
            mifp_pkg::S_FIRST: begin
                n_c     = i_rdata;
                o_raddr = AW'(1);
                n_k     = AW'(1);
            end
            // Drop the smaller one below, carry the larger one upward
            mifp_pkg::S_CMP: begin
                o_we    = 1'b1;
                o_waddr = r_k - AW'(1);
                o_wdata = w_swap ? i_rdata : r_c;
                n_c     = w_swap ? r_c : i_rdata;
                o_raddr = r_k + AW'(1);
                n_k     = r_k + AW'(1);
            end
            // Park the pass maximum at the top and shrink the range
            mifp_pkg::S_TAIL: begin
                o_we    = 1'b1;
                o_waddr = r_hi;
                o_wdata = r_c;
                n_hi    = r_hi - AW'(1);
                n_k     = '0;
            end
            mifp_pkg::S_EMRD: begin
                o_raddr = r_k;
            end
            // Load one result when the output register is free, prefetch the next entry
            mifp_pkg::S_EMIT: begin
                o_raddr = r_k;
                if (i_out_free) begin
                    o_ctl.load  = 1'b1;
                    o_ctl.clear = w_emit_last;
                    o_raddr     = r_k + AW'(1);
                    n_k         = r_k + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mifp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Counters and carry
    always_ff @(posedge i_clk) begin
        r_k  <= n_k;
        r_hi <= n_hi;
        r_c  <= n_c;
    end

endmodule

@@ src/mifp_check.sv @@
// Port-level checker for the marked input field parser, bound to the top level.
module mifp_check #(
    parameter int MAX_SPECIAL = 32,
    parameter int MAX_STRING  = 256
) (
    input logic                                        i_clk,
    input logic                                        i_rst_n,
    input logic                                        i_s_tvalid,
    input logic                                        o_s_tready,
    input logic                                        i_s_tlast,
    input logic                                        o_m_tvalid,
    input logic                                        i_m_tready,
    input logic [((($clog2(MAX_STRING+1)+$clog2(MAX_SPECIAL+1)+26)+7)/8)*8-1:0] o_m_tdata,
    input logic                                        o_m_tuser,
    input logic                                        o_m_tlast
);

    localparam int IW = $clog2(MAX_STRING + 1);
    localparam int CW = $clog2(MAX_SPECIAL + 1);
    localparam int BL = IW + CW + 17;

    logic       w_out_acc;
    logic [7:0] w_byte;
    logic [7:0] r_prev;
    logic       r_in_run;

    assign w_out_acc = o_m_tvalid && i_m_tready;
    assign w_byte    = o_m_tdata[BL+7:BL];

    // Track the previous byte of the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (w_out_acc) begin
            r_in_run <= !o_m_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            r_prev <= w_byte;
        end
    end

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result changed while stalled");

    // Emit bytes of a run in ascending order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_in_run) |-> (w_byte >= r_prev))
        else $error("run not in ascending order");

    // An empty run is a single result with no byte
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && (w_byte == 8'd0)
            && (o_m_tdata[BL-1:IW+17] == '0)))
        else $error("empty run malformed");

    // Stop taking input only after the last byte of a string
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(i_s_tvalid && i_s_tlast))
        else $error("input stalled without a last byte");

endmodule

bind marked_input_field_parser mifp_check #(
    .MAX_SPECIAL (MAX_SPECIAL),
    .MAX_STRING  (MAX_STRING)
) u_mifp_check (.*);
